// ===== rtl/rrff_pkg.sv =====
// rrff_pkg: shared types, message codes and action codes of the route request flood filter
// no dependencies

package rrff_pkg;

  localparam logic [7:0]  MSG_REQ    = 8'd1;
  localparam logic [7:0]  MSG_REPLY  = 8'd2;
  localparam logic [7:0]  MSG_ERROR  = 8'd3;
  localparam logic [7:0]  MSG_ACK    = 8'd4;
  localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;

  localparam int unsigned CFG_IW = 8;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_FILTER_EN = 8'd0;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 8'd1;
  localparam logic [15:0] THRESH_RESET = 16'd10;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_HELLO           = 3'd0,
    ACT_REQ_FWD         = 3'd1,
    ACT_REQ_DROP_LISTED = 3'd2,
    ACT_REQ_DROP_NEW    = 3'd3,
    ACT_REPLY           = 3'd4,
    ACT_ERROR           = 3'd5,
    ACT_ACK             = 3'd6,
    ACT_UNKNOWN         = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

  typedef struct packed {
    logic    done;
    action_e action;
  } cnt_res_t;

  function automatic action_e classify_msg(logic [7:0] t, logic [31:0] dst, logic [7:0] hop);
    action_e a;
    if (t == MSG_REPLY && hop == 8'd0 && dst == BCAST_ADDR) begin
      a = ACT_HELLO;
    end else begin
      unique case (t)
        MSG_REQ:   a = ACT_REQ_FWD;
        MSG_REPLY: a = ACT_REPLY;
        MSG_ERROR: a = ACT_ERROR;
        MSG_ACK:   a = ACT_ACK;
        default:   a = ACT_UNKNOWN;
      endcase
    end
    return a;
  endfunction

endpackage

// ===== rtl/rrff_if.sv =====
// rrff_in_if / rrff_out_if: valid-ready channels for messages and actions
// no dependencies

interface rrff_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  hop_limit;

  modport source (output valid, msg_type, src_ip, dst_ip, hop_limit, input ready);
  modport sink   (input valid, msg_type, src_ip, dst_ip, hop_limit, output ready);
endinterface

interface rrff_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       table_full;

  modport source (output valid, action, table_full, input ready);
  modport sink   (input valid, action, table_full, output ready);
endinterface

// ===== rtl/rrff_src_table.sv =====
// rrff_src_table: source address memory with a sequential lookup scan
// depends on rrff_pkg

module rrff_src_table
  import rrff_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      key_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] fill_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx_i,
  input  logic [31:0]                      wr_data_i,
  output scan_res_t                        res_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [31:0]   mem_q [TABLE_ENTRIES];
  logic [31:0]   rdata_q;
  logic          busy_q;
  logic [CW-1:0] addr_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          issue;
  logic          hit;
  logic          done;

  assign issue = busy_q && (addr_q < fill_i);
  assign hit   = busy_q && cmp_vld_q && (rdata_q == key_i);
  // the last read is issued in the cycle before the address reaches the fill level
  assign done  = busy_q && (hit || (addr_q >= fill_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (issue) begin
      rdata_q   <= mem_q[addr_q[IW-1:0]];
      cmp_idx_q <= addr_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else if (start_i) begin
      busy_q    <= 1'b1;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else if (done) begin
      busy_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        addr_q <= addr_q + CW'(1);
      end
      cmp_vld_q <= issue;
    end
  end

  assign res_o.done = done;
  assign res_o.hit  = hit;
  assign idx_o      = cmp_idx_q;

endmodule

// ===== rtl/rrff_cnt_table.sv =====
// rrff_cnt_table: per-entry request count and blacklist memory, read-modify-write
// depends on rrff_pkg

module rrff_cnt_table
  import rrff_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             upd_i,
  input  logic                             ins_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx_i,
  input  logic [15:0]                      thresh_i,
  output cnt_res_t                         res_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  // entry word: blacklisted flag on top of the 16-bit count
  logic [16:0]   mem_q [TABLE_ENTRIES];
  logic [16:0]   rdata_q;
  logic          pend_q;
  logic [IW-1:0] idx_q;
  logic [15:0]   cnt_n;
  logic          over;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [16:0]   wr_data;

  assign cnt_n   = (rdata_q[15:0] == CNT_MAX) ? rdata_q[15:0] : rdata_q[15:0] + 16'd1;
  assign over    = cnt_n > thresh_i;
  // a listed source is left as it is
  assign wr_en   = ins_i || (pend_q && !rdata_q[16]);
  assign wr_idx  = ins_i ? idx_i : idx_q;
  assign wr_data = ins_i ? {1'b0, 16'd1} : {over, cnt_n};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (upd_i) begin
      rdata_q <= mem_q[idx_i];
      idx_q   <= idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= upd_i;
    end
  end

  always_comb begin
    res_o.done = pend_q;
    if (rdata_q[16]) begin
      res_o.action = ACT_REQ_DROP_LISTED;
    end else if (over) begin
      res_o.action = ACT_REQ_DROP_NEW;
    end else begin
      res_o.action = ACT_REQ_FWD;
    end
  end

endmodule

// ===== rtl/route_request_flood_filter_top.sv =====
// route_request_flood_filter_top: classifies routing control messages and filters
// route request floods per source; depends on rrff_pkg, rrff_if, rrff_src_table, rrff_cnt_table
//
//  channel  | dir | handshake      | payload
//  in_if    | in  | valid / ready  | msg_type, src_ip, dst_ip, hop_limit
//  out_if   | out | valid / ready  | action, table_full
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i (write only)
//
// a non-request message, or any request with the filter off, goes from ST_IDLE to ST_DONE and
// from there into the output register; a filtered request scans the source memory at one entry
// per cycle until a hit or the fill level, at most TABLE_ENTRIES entries, and for a known source
// then updates its count in ST_COUNT; the next transaction is taken once ST_IDLE is reached again
// one message is worked on at a time; the next is taken while a result waits in the output
// register, and a finished result waits in ST_DONE while the output register is still full
// reset clears the fill level and control state; memory contents are not cleared

module route_request_flood_filter_top
  import rrff_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  rrff_in_if.sink           in_if,
  rrff_out_if.source        out_if
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  state_e        state_q, state_d;
  logic          filter_en_q;
  logic [15:0]   thresh_q;
  logic [CW-1:0] fill_q;
  logic [31:0]   src_q;
  action_e       act_q, act_d;
  logic          full_q, full_d;
  logic          out_valid_q;
  action_e       out_act_q;
  logic          out_full_q;

  logic          in_ready;
  logic          accept;
  logic          go_scan;
  logic          out_free;
  logic          tbl_full;
  logic          scan_start;
  logic          cnt_upd;
  logic          ins;
  logic          out_load;
  scan_res_t     scan_res;
  logic [IW-1:0] scan_idx;
  cnt_res_t      cnt_res;

  assign accept   = in_if.valid && in_ready;
  assign go_scan  = (in_if.msg_type == MSG_REQ) && filter_en_q;
  assign out_free = !out_valid_q || out_if.ready;
  assign tbl_full = (fill_q == CW'(TABLE_ENTRIES));

  rrff_src_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_src_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .key_i    (src_q),
    .fill_i   (fill_q),
    .wr_en_i  (ins),
    .wr_idx_i (fill_q[IW-1:0]),
    .wr_data_i(src_q),
    .res_o    (scan_res),
    .idx_o    (scan_idx)
  );

  rrff_cnt_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_cnt_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (cnt_upd),
    .ins_i   (ins),
    .idx_i   (cnt_upd ? scan_idx : fill_q[IW-1:0]),
    .thresh_i(thresh_q),
    .res_o   (cnt_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = go_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = scan_res.hit ? ST_COUNT : ST_DONE;
        end
      end
      ST_COUNT: begin
        if (cnt_res.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    cnt_upd    = 1'b0;
    ins        = 1'b0;
    out_load   = 1'b0;
    act_d      = act_q;
    full_d     = full_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          scan_start = go_scan;
          act_d      = classify_msg(in_if.msg_type, in_if.dst_ip, in_if.hop_limit);
          full_d     = 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            cnt_upd = 1'b1;
          end else begin
            // unknown source: enter it, or forward it untracked when no entry is left
            act_d  = ACT_REQ_FWD;
            ins    = !tbl_full;
            full_d = tbl_full;
          end
        end
      end
      ST_COUNT: begin
        if (cnt_res.done) begin
          act_d = cnt_res.action;
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      filter_en_q <= 1'b0;
      thresh_q    <= THRESH_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == REG_FILTER_EN) begin
        filter_en_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_idx_i == REG_THRESHOLD) begin
        thresh_q <= cfg_data_i[15:0];
      end
      if (ins) begin
        fill_q <= fill_q + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= in_if.src_ip;
    end
    act_q  <= act_d;
    full_q <= full_d;
    if (out_load) begin
      out_act_q  <= act_q;
      out_full_q <= full_q;
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.action     = out_act_q;
  assign out_if.table_full = out_full_q;

endmodule

// ===== rtl/rrff_chk.sv =====
// rrff_chk: port-level assertions on route_request_flood_filter_top, bound to it
// depends on rrff_pkg and route_request_flood_filter_top

module rrff_chk
  import rrff_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_action_i,
  input logic       out_full_i
);

  // a waiting result holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_action_i) && $stable(out_full_i))
    else $error("result changed while stalled");

  // a full table only ever shows on a forwarded request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_full_i |-> out_action_i == ACT_REQ_FWD)
    else $error("table_full on a result that is not a forwarded request");

  // one message at a time: no new transaction right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a message is still in work");

  // a new result is loaded only while the input side is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a message in work");

endmodule

bind route_request_flood_filter_top rrff_chk u_rrff_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_action_i(out_if.action),
  .out_full_i  (out_if.table_full)
);
